/* design/tcpu_pkg.sv */
// shared types and constants for the tiny 16-bit cpu execute block
`default_nettype none

package tcpu_pkg;

  localparam int unsigned InstrW = 16;
  localparam int unsigned DataW  = 16;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned NumRegs = 16;
  localparam int unsigned MemAddrW = 8;
  localparam int unsigned DataDepth = 256;
  localparam int unsigned PcW = 8;

  typedef enum logic [3:0] {
    OP_LOAD     = 4'd0,
    OP_STORE    = 4'd1,
    OP_STORE_RI = 4'd2,
    OP_LOAD_IMM = 4'd3,
    OP_ADD      = 4'd4,
    OP_SUB      = 4'd5,
    OP_BRZ      = 4'd8,
    OP_HALT     = 4'd15
  } op_e;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic                en;
    logic [MemAddrW-1:0] addr;
    logic [DataW-1:0]    data;
  } mem_wr_t;

endpackage

`default_nettype wire

/* design/tcpu_regfile.sv */
// register file: two registered read ports, one write port, reads zero until written
`default_nettype none

module tcpu_regfile (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            rd_en_i,
  input  wire logic [tcpu_pkg::RegIdxW-1:0]    rd_addr_a_i,
  input  wire logic [tcpu_pkg::RegIdxW-1:0]    rd_addr_b_i,
  output logic      [tcpu_pkg::DataW-1:0]      rd_data_a_o,
  output logic      [tcpu_pkg::DataW-1:0]      rd_data_b_o,
  input  wire tcpu_pkg::rf_wr_t                wr_i
);

  logic [tcpu_pkg::DataW-1:0] mem [tcpu_pkg::NumRegs];
  logic [tcpu_pkg::NumRegs-1:0] vld_q;

  logic [tcpu_pkg::DataW-1:0] rd_a_q, rd_b_q;
  logic                       vld_a_q, vld_b_q;
  logic                       fwd_a_q, fwd_b_q;
  logic [tcpu_pkg::DataW-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q     <= mem[rd_addr_a_i];
      rd_b_q     <= mem[rd_addr_b_i];
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_a_q <= vld_q[rd_addr_a_i];
        vld_b_q <= vld_q[rd_addr_b_i];
        // write landing on the same edge as the read
        fwd_a_q <= wr_i.en && (wr_i.idx == rd_addr_a_i);
        fwd_b_q <= wr_i.en && (wr_i.idx == rd_addr_b_i);
      end
    end
  end

  assign rd_data_a_o = fwd_a_q ? fwd_data_q : (vld_a_q ? rd_a_q : '0);
  assign rd_data_b_o = fwd_b_q ? fwd_data_q : (vld_b_q ? rd_b_q : '0);

endmodule

`default_nettype wire

/* design/tcpu_dmem.sv */
// data memory: one registered read port, one write port, reads zero until written
`default_nettype none

module tcpu_dmem (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            rd_en_i,
  input  wire logic [tcpu_pkg::MemAddrW-1:0]   rd_addr_i,
  output logic      [tcpu_pkg::DataW-1:0]      rd_data_o,
  input  wire tcpu_pkg::mem_wr_t               wr_i
);

  logic [tcpu_pkg::DataW-1:0] mem [tcpu_pkg::DataDepth];
  logic [tcpu_pkg::DataDepth-1:0] vld_q;

  logic [tcpu_pkg::DataW-1:0] rd_q;
  logic [tcpu_pkg::DataW-1:0] fwd_data_q;
  logic                       rd_vld_q;
  logic                       fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        fwd_q    <= wr_i.en && (wr_i.addr == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);

endmodule

`default_nettype wire

/* design/tiny_16bit_cpu_execute.sv */
// top level: execute stage of the tiny 16-bit cpu
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o     instruction_i
//   out       output     out_valid_o / out_ready_i   next_pc_o, halted_o, reg_*_o, mem_*_o
//
// one item per cycle sustained while the output is not stalled; on accept the register file
// and data memory reads are registered, then execute and write back load the result register.
// reset clears the pc, the halt flag and the valid bits of both memories at once,
// so no clearing pass is needed.
// a stalled output holds the result register; the exec stage and the input back up behind it.
`default_nettype none

module tiny_16bit_cpu_execute (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [tcpu_pkg::InstrW-1:0]       instruction_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [tcpu_pkg::PcW-1:0]          next_pc_o,
  output logic                                   halted_o,
  output logic                                   reg_written_o,
  output logic      [tcpu_pkg::RegIdxW-1:0]      reg_index_o,
  output logic      [tcpu_pkg::DataW-1:0]        reg_value_o,
  output logic                                   mem_written_o,
  output logic      [tcpu_pkg::MemAddrW-1:0]     mem_address_o,
  output logic      [tcpu_pkg::DataW-1:0]        mem_value_o
);

  logic in_fire, exec_go;

  logic                          s1_valid_q;
  logic [tcpu_pkg::InstrW-1:0]   s1_instr_q;

  logic [tcpu_pkg::PcW-1:0]      pc_q, pc_d;
  logic                          halt_q, halt_d;

  tcpu_pkg::op_e                 in_op, op;
  logic [tcpu_pkg::RegIdxW-1:0]  rd_addr_a;
  logic [tcpu_pkg::DataW-1:0]    rf_a, rf_b, dm_rd;
  logic [tcpu_pkg::RegIdxW-1:0]  na, nb;
  logic [tcpu_pkg::MemAddrW-1:0] k;
  logic [tcpu_pkg::PcW-1:0]      pc_inc;

  tcpu_pkg::rf_wr_t  rf_wr;
  tcpu_pkg::mem_wr_t dm_wr;

  assign exec_go    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || exec_go;
  assign in_fire    = in_valid_i && in_ready_o;

  // port a serves B for indirect store and alu ops, A otherwise; port b always serves C
  assign in_op = tcpu_pkg::op_e'(instruction_i[15:12]);
  always_comb begin
    unique case (in_op) inside
      tcpu_pkg::OP_STORE_RI, tcpu_pkg::OP_ADD, tcpu_pkg::OP_SUB: rd_addr_a = instruction_i[7:4];
      default: rd_addr_a = instruction_i[11:8];
    endcase
  end

  tcpu_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_fire),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (instruction_i[3:0]),
    .rd_data_a_o (rf_a),
    .rd_data_b_o (rf_b),
    .wr_i        (rf_wr)
  );

  tcpu_dmem u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (instruction_i[7:0]),
    .rd_data_o (dm_rd),
    .wr_i      (dm_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_instr_q <= instruction_i;
    end
  end

  assign op     = tcpu_pkg::op_e'(s1_instr_q[15:12]);
  assign na     = s1_instr_q[11:8];
  assign nb     = s1_instr_q[7:4];
  assign k      = s1_instr_q[7:0];
  assign pc_inc = pc_q + tcpu_pkg::PcW'(1);

  // execute; state only changes when the item moves into the output register
  always_comb begin
    rf_wr  = '0;
    dm_wr  = '0;
    pc_d   = pc_q;
    halt_d = halt_q;
    if (!halt_q) begin
      pc_d = pc_inc;
      unique case (op)
        tcpu_pkg::OP_LOAD: begin
          rf_wr = '{en: 1'b1, idx: na, data: dm_rd};
        end
        tcpu_pkg::OP_STORE: begin
          dm_wr = '{en: 1'b1, addr: k, data: rf_a};
        end
        tcpu_pkg::OP_STORE_RI: begin
          dm_wr = '{en: 1'b1, addr: rf_a[tcpu_pkg::MemAddrW-1:0], data: rf_b};
        end
        tcpu_pkg::OP_LOAD_IMM: begin
          rf_wr = '{en: 1'b1, idx: na, data: tcpu_pkg::DataW'(k)};
        end
        tcpu_pkg::OP_ADD: begin
          rf_wr = '{en: 1'b1, idx: nb, data: rf_a + rf_b};
        end
        tcpu_pkg::OP_SUB: begin
          rf_wr = '{en: 1'b1, idx: nb, data: rf_a - rf_b};
        end
        tcpu_pkg::OP_BRZ: begin
          // signed 8-bit offset wraps the same as an unsigned add mod 256
          if (rf_a == '0) begin
            pc_d = pc_inc + k;
          end
        end
        tcpu_pkg::OP_HALT: begin
          halt_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (!exec_go) begin
      rf_wr.en = 1'b0;
      dm_wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (exec_go) begin
        pc_q   <= pc_d;
        halt_q <= halt_d;
      end
      if (exec_go) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      next_pc_o     <= pc_d;
      halted_o      <= halt_d;
      reg_written_o <= rf_wr.en;
      reg_index_o   <= rf_wr.idx;
      reg_value_o   <= rf_wr.data;
      mem_written_o <= dm_wr.en;
      mem_address_o <= dm_wr.addr;
      mem_value_o   <= dm_wr.data;
    end
  end

endmodule

`default_nettype wire
